// ----- hdl/mjdc_pkg.sv -----
// mjdc_pkg: constants and types for the mjd to calendar time core
// widths, divider reciprocals and calendar constants; no dependencies
`default_nettype none

package mjdc_pkg;

    // input field widths
    localparam int DAY_NUMBER_BITS = 20;
    localparam int FRACTION_BITS   = 32;

    // stream payload widths, packed from bit 0 and padded to whole bytes
    localparam int IN_FIELD_BITS  = DAY_NUMBER_BITS + FRACTION_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 13 + 4 + 5 + 5 + 6 + 6 + 32;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // julian day number algorithm constants
    localparam int JDN_OFFSET   = 2400001;
    localparam int JDN_BIAS     = 32044;
    localparam int DAY_OFFSET   = JDN_OFFSET + JDN_BIAS;
    localparam int DAYS_400Y    = 146097;
    localparam int DAYS_4Y      = 1461;
    localparam int DAYS_5M      = 153;
    localparam int YEAR_BIAS    = 4800;
    localparam int YEARS_CENT   = 100;

    // first divide: (4a+3) / 146097, width follows the day number width
    localparam int A_MAX        = (1 << DAY_NUMBER_BITS) - 1 + DAY_OFFSET;
    localparam int X1_BITS      = $clog2(4 * A_MAX + 4);
    localparam int A_BITS       = X1_BITS - 2;
    localparam int Q1_MAX       = (4 * A_MAX + 3) / DAYS_400Y;
    localparam int Q1_BITS      = $clog2(Q1_MAX + 1);
    localparam int M1           = (1 << X1_BITS) / DAYS_400Y;
    localparam int M1_BITS      = $clog2(M1 + 1);
    localparam int R1_BITS      = 19;   // raw remainder below twice the divisor

    // second divide: (4c+3) / 1461, x below 2^18
    localparam int X2_BITS      = 18;
    localparam int M2           = (1 << X2_BITS) / DAYS_4Y;
    localparam int Q2_BITS      = 7;
    localparam int R2_BITS      = 12;

    // third divide: (5e+2) / 153, x below 2^11
    localparam int X3_BITS      = 11;
    localparam int M3           = (1 << X3_BITS) / DAYS_5M;
    localparam int Q3_BITS      = 4;
    localparam int R3_BITS      = 9;

    // day from remainder / 5, exact below 1024
    localparam int DIV5_MUL     = 205;
    localparam int DIV5_SHIFT   = 10;

    localparam int YS_BITS      = Q1_BITS + 8;

    // time of day: 86400 = 675 * 128
    localparam int SECS_MUL     = 675;
    localparam int P_BITS       = FRACTION_BITS + 10;
    localparam int SF_BITS      = FRACTION_BITS - 7;
    localparam int SECS_BITS    = P_BITS - SF_BITS;
    localparam int SECS_HOUR    = 3600;
    localparam int SECS_MIN     = 60;
    localparam int M_HOUR       = (1 << SECS_BITS) / SECS_HOUR;
    localparam int M_MIN        = (1 << 12) / SECS_MIN;

    // pipeline depth
    localparam int STAGES       = 11;

    typedef struct packed {
        logic [31:0] sub;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
    } t_tod;

endpackage

`default_nettype wire

// ----- hdl/mjd_to_calendar_time_core.sv -----
// mjd_to_calendar_time_core: modified julian day and day fraction to date and time
// depends on mjdc_pkg for widths, reciprocals and the time of day struct
`default_nettype none

// Converts a modified julian day number and a 32-bit fraction of the day into a
// gregorian year, month and day plus hour, minute, whole second and a 32-bit
// sub-second fraction. The core takes one item per clock cycle while the output
// is not stalled, with no state between items. The pipeline depth is
// set by the date chain: an input stage that forms 4a+3, three divisions by
// constants (146097, 1461 and 153), each built as a reciprocal estimate, a
// remainder and a one-step correction in three register stages, plus a final stage
// for day, month and year. The time of day runs alongside in seven stages and is
// delayed to meet the date. Every stage has its own valid bit, so bubbles close up
// while the output is stalled and s_axis_tready stays high as long as any stage is
// empty.
module mjd_to_calendar_time_core
    import mjdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // tdata: day_number, day_fraction, zero pad
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // tdata: year, month, day_of_month, hour, minute, second, second_fraction, zero pad
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata
);

    // ---------------------------------------------------------------
    // handshake: per-stage valid bits, a stage loads when it is empty
    // or its content moves on
    // ---------------------------------------------------------------
    logic [STAGES:1]   r_vld;
    logic [STAGES:1]   w_vin;
    logic [STAGES+1:1] w_rdy;

    always_comb begin
        w_rdy[STAGES+1] = m_axis_tready;
        for (int i = STAGES; i >= 1; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    assign w_vin         = {r_vld[STAGES-1:1], s_axis_tvalid};
    assign s_axis_tready = w_rdy[1];
    assign m_axis_tvalid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 1; i <= STAGES; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= w_vin[i];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // input fields
    // ---------------------------------------------------------------
    logic [DAY_NUMBER_BITS-1:0] w_mjd;
    logic [FRACTION_BITS-1:0]   w_frac;

    assign w_mjd  = s_axis_tdata[DAY_NUMBER_BITS-1:0];
    assign w_frac = s_axis_tdata[DAY_NUMBER_BITS +: FRACTION_BITS];

    // ---------------------------------------------------------------
    // date chain, combinational terms per stage
    // ---------------------------------------------------------------
    logic [A_BITS-1:0]          w_a;
    logic [X1_BITS+M1_BITS-1:0] w_q1_prod;
    logic [X1_BITS-1:0]         w_r1_full;
    logic                       w_r1_ge;
    logic [R1_BITS-1:0]         w_r1;
    logic [X2_BITS+7:0]         w_q2_prod;
    logic [X2_BITS-1:0]         w_r2_full;
    logic                       w_r2_ge;
    logic [R2_BITS-1:0]         w_r2;
    logic [8:0]                 w_e;
    logic [X3_BITS+3:0]         w_q3_prod;
    logic [X3_BITS-1:0]         w_r3_full;
    logic                       w_r3_ge;
    logic [R3_BITS-1:0]         w_r3;
    logic [14:0]                w_div5;
    logic                       w_wrap;
    logic [YS_BITS-1:0]         w_year;

    // registers of the date chain, numbered by stage
    logic [X1_BITS-1:0] r1_x1,  r2_x1;
    logic [Q1_BITS-1:0] r2_q1e, r3_q1e;
    logic [R1_BITS-1:0] r3_r1raw;
    logic [Q1_BITS-1:0] r4_b, r5_b, r6_b, r7_b, r8_b, r9_b, r10_b;
    logic [X2_BITS-1:0] r4_x2, r5_x2;
    logic [Q2_BITS-1:0] r5_q2e, r6_q2e;
    logic [R2_BITS-1:0] r6_r2raw;
    logic [Q2_BITS-1:0] r7_d, r8_d, r9_d, r10_d;
    logic [X3_BITS-1:0] r7_x3, r8_x3;
    logic [Q3_BITS-1:0] r8_q3e, r9_q3e;
    logic [R3_BITS-1:0] r9_r3raw;
    logic [Q3_BITS-1:0] r10_m;
    logic [7:0]         r10_r3;
    logic [12:0]        r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;

    // stage 1: a = mjd + jdn offset + bias, then 4a+3
    assign w_a = A_BITS'(w_mjd) + A_BITS'(DAY_OFFSET);

    // stage 2: quotient estimate by reciprocal, never above the true quotient
    assign w_q1_prod = (X1_BITS+M1_BITS)'(r1_x1) * (X1_BITS+M1_BITS)'(M1);

    // stage 3: raw remainder, below twice the divisor
    assign w_r1_full = r2_x1 - X1_BITS'(r2_q1e) * X1_BITS'(DAYS_400Y);

    // stage 4: correct by one, c = remainder / 4
    assign w_r1_ge = r3_r1raw >= R1_BITS'(DAYS_400Y);
    assign w_r1    = w_r1_ge ? r3_r1raw - R1_BITS'(DAYS_400Y) : r3_r1raw;

    // stage 5 to 7: same for 1461
    assign w_q2_prod = (X2_BITS+8)'(r4_x2) * (X2_BITS+8)'(M2);
    assign w_r2_full = r5_x2 - X2_BITS'(r5_q2e) * X2_BITS'(DAYS_4Y);
    assign w_r2_ge   = r6_r2raw >= R2_BITS'(DAYS_4Y);
    assign w_r2      = w_r2_ge ? r6_r2raw - R2_BITS'(DAYS_4Y) : r6_r2raw;
    assign w_e       = w_r2[10:2];

    // stage 8 to 10: same for 153, remainder gives the day
    assign w_q3_prod = (X3_BITS+4)'(r7_x3) * (X3_BITS+4)'(M3);
    assign w_r3_full = r8_x3 - X3_BITS'(r8_q3e) * X3_BITS'(DAYS_5M);
    assign w_r3_ge   = r9_r3raw >= R3_BITS'(DAYS_5M);
    assign w_r3      = w_r3_ge ? r9_r3raw - R3_BITS'(DAYS_5M) : r9_r3raw;

    // stage 11: day, month and year, march-based month wraps at 10
    assign w_div5 = 15'(r10_r3) * 15'(DIV5_MUL);
    assign w_wrap = r10_m >= Q3_BITS'(10);
    assign w_year = YS_BITS'(r10_b) * YS_BITS'(YEARS_CENT) + YS_BITS'(r10_d)
                  + YS_BITS'(w_wrap) - YS_BITS'(YEAR_BIAS);

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_x1 <= {w_a, 2'b11};
        end
        if (w_rdy[2]) begin
            r2_x1  <= r1_x1;
            r2_q1e <= w_q1_prod[X1_BITS +: Q1_BITS];
        end
        if (w_rdy[3]) begin
            r3_q1e   <= r2_q1e;
            r3_r1raw <= w_r1_full[R1_BITS-1:0];
        end
        if (w_rdy[4]) begin
            r4_b  <= r3_q1e + Q1_BITS'(w_r1_ge);
            r4_x2 <= {w_r1[17:2], 2'b11};
        end
        if (w_rdy[5]) begin
            r5_b   <= r4_b;
            r5_x2  <= r4_x2;
            r5_q2e <= w_q2_prod[X2_BITS +: Q2_BITS];
        end
        if (w_rdy[6]) begin
            r6_b     <= r5_b;
            r6_q2e   <= r5_q2e;
            r6_r2raw <= w_r2_full[R2_BITS-1:0];
        end
        if (w_rdy[7]) begin
            r7_b  <= r6_b;
            r7_d  <= r6_q2e + Q2_BITS'(w_r2_ge);
            r7_x3 <= X3_BITS'(w_e) * X3_BITS'(5) + X3_BITS'(2);
        end
        if (w_rdy[8]) begin
            r8_b   <= r7_b;
            r8_d   <= r7_d;
            r8_x3  <= r7_x3;
            r8_q3e <= w_q3_prod[X3_BITS +: Q3_BITS];
        end
        if (w_rdy[9]) begin
            r9_b     <= r8_b;
            r9_d     <= r8_d;
            r9_q3e   <= r8_q3e;
            r9_r3raw <= w_r3_full[R3_BITS-1:0];
        end
        if (w_rdy[10]) begin
            r10_b  <= r9_b;
            r10_d  <= r9_d;
            r10_m  <= r9_q3e + Q3_BITS'(w_r3_ge);
            r10_r3 <= w_r3[7:0];
        end
        if (w_rdy[11]) begin
            r_year  <= w_year[12:0];
            r_month <= w_wrap ? r10_m - 4'd9 : r10_m + 4'd3;
            r_day   <= w_div5[14:DIV5_SHIFT] + 5'd1;
        end
    end

    // ---------------------------------------------------------------
    // time of day chain
    // ---------------------------------------------------------------
    logic [P_BITS-1:0]    w_p;
    logic [31:0]          w_sub32;
    logic [21:0]          w_hour_prod;
    logic [SECS_BITS-1:0] w_rem_full;
    logic                 w_rem_ge;
    logic [12:0]          w_rem;
    logic [17:0]          w_min_prod;
    logic [11:0]          w_sec_full;
    logic                 w_sec_ge;
    logic [6:0]           w_sec;

    logic [SECS_BITS-1:0] r1_secs, r2_secs;
    logic [31:0]          r1_sub, r2_sub, r3_sub, r4_sub, r5_sub, r6_sub;
    logic [4:0]           r2_hour_e, r3_hour_e, r4_hour, r5_hour, r6_hour;
    logic [12:0]          r3_rem_raw;
    logic [11:0]          r4_rem, r5_rem;
    logic [5:0]           r5_min_e, r6_min_e;
    logic [6:0]           r6_sec_raw;
    t_tod                 r_tod [7:STAGES];

    // seconds of day = fraction * 675 with 7 fewer fraction bits
    assign w_p = P_BITS'(w_frac) * P_BITS'(SECS_MUL);

    generate
        if (SF_BITS >= 32) begin : g_sub_trunc
            assign w_sub32 = w_p[SF_BITS-1 -: 32];
        end else begin : g_sub_pad
            assign w_sub32 = {w_p[SF_BITS-1:0], (32-SF_BITS)'(0)};
        end
    endgenerate

    // hour = secs / 3600 and minute / second from the remainder
    assign w_hour_prod = 22'(r1_secs) * 22'(M_HOUR);
    assign w_rem_full  = r2_secs - SECS_BITS'(r2_hour_e) * SECS_BITS'(SECS_HOUR);
    assign w_rem_ge    = r3_rem_raw >= 13'(SECS_HOUR);
    assign w_rem       = w_rem_ge ? r3_rem_raw - 13'(SECS_HOUR) : r3_rem_raw;
    assign w_min_prod  = 18'(r4_rem) * 18'(M_MIN);
    assign w_sec_full  = r5_rem - 12'(r5_min_e) * 12'(SECS_MIN);
    assign w_sec_ge    = r6_sec_raw >= 7'(SECS_MIN);
    assign w_sec       = w_sec_ge ? r6_sec_raw - 7'(SECS_MIN) : r6_sec_raw;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_secs <= w_p[P_BITS-1 -: SECS_BITS];
            r1_sub  <= w_sub32;
        end
        if (w_rdy[2]) begin
            r2_secs   <= r1_secs;
            r2_sub    <= r1_sub;
            r2_hour_e <= w_hour_prod[SECS_BITS +: 5];
        end
        if (w_rdy[3]) begin
            r3_sub     <= r2_sub;
            r3_hour_e  <= r2_hour_e;
            r3_rem_raw <= w_rem_full[12:0];
        end
        if (w_rdy[4]) begin
            r4_sub  <= r3_sub;
            r4_hour <= r3_hour_e + 5'(w_rem_ge);
            r4_rem  <= w_rem[11:0];
        end
        if (w_rdy[5]) begin
            r5_sub   <= r4_sub;
            r5_hour  <= r4_hour;
            r5_rem   <= r4_rem;
            r5_min_e <= w_min_prod[17:12];
        end
        if (w_rdy[6]) begin
            r6_sub     <= r5_sub;
            r6_hour    <= r5_hour;
            r6_min_e   <= r5_min_e;
            r6_sec_raw <= w_sec_full[6:0];
        end
        if (w_rdy[7]) begin
            r_tod[7].sub    <= r6_sub;
            r_tod[7].hour   <= r6_hour;
            r_tod[7].minute <= r6_min_e + 6'(w_sec_ge);
            r_tod[7].second <= w_sec[5:0];
        end
        // delay line to meet the date chain
        for (int i = 8; i <= STAGES; i++) begin
            if (w_rdy[i]) begin
                r_tod[i] <= r_tod[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // output packing, year in the lowest bits
    // ---------------------------------------------------------------
    assign m_axis_tdata = OUT_DATA_BITS'({r_tod[STAGES].sub, r_tod[STAGES].second,
                                          r_tod[STAGES].minute, r_tod[STAGES].hour,
                                          r_day, r_month, r_year});

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while every stage is full and stalled");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_month >= 4'd1) && (r_month <= 4'd12) && (r_day >= 5'd1))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_tod[STAGES].hour <= 5'd23) && (r_tod[STAGES].minute <= 6'd59)
                          && (r_tod[STAGES].second <= 6'd59))
        else $error("time of day out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ----- bench/mjdc_checker.sv -----
// mjdc_checker: watches both stream channels of the mjd to calendar time core,
// predicts the calendar date and time of day for every accepted item and compares results
// depends on mjdc_pkg for the field and stream widths
`default_nettype none

module mjdc_checker
    import mjdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    input  wire logic                     i_s_tready,
    // tdata: day_number, day_fraction, zero pad
    input  wire logic [IN_DATA_BITS-1:0]  i_s_tdata,
    input  wire logic                     i_m_tvalid,
    input  wire logic                     i_m_tready,
    // tdata: year, month, day_of_month, hour, minute, second, second_fraction, zero pad
    input  wire logic [OUT_DATA_BITS-1:0] i_m_tdata,
    output int                            o_fail_count,
    output int                            o_pending_count
);

    localparam int SCALE_BITS = FRACTION_BITS - 7;   // 86400 = 675 * 128
    localparam int REPORT_MAX = 10;

    // first member sits in the top bits, so year lands at bit 0
    typedef struct packed {
        logic [31:0] second_fraction;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [12:0] year;
    } t_stamp;

    t_stamp stamps_due[$];

    function automatic t_stamp civil_time_of(logic [DAY_NUMBER_BITS-1:0] mjd,
                                             logic [FRACTION_BITS-1:0]   frac);
        logic [63:0] a, q400, c, q4, e, mq, wrap, p, secs, rem, sub;
        t_stamp      r;
        a    = 64'(mjd) + JDN_OFFSET + JDN_BIAS;
        q400 = (4 * a + 3) / DAYS_400Y;
        c    = a - (DAYS_400Y * q400) / 4;
        q4   = (4 * c + 3) / DAYS_4Y;
        e    = c - (DAYS_4Y * q4) / 4;
        mq   = (5 * e + 2) / DAYS_5M;
        wrap = mq / 10;                     // march-based month index past december
        r.day_of_month = 5'(e - (DAYS_5M * mq + 2) / 5 + 1);
        r.month        = 4'(mq + 3 - 12 * wrap);
        r.year         = 13'(100 * q400 + q4 + wrap - YEAR_BIAS);

        p    = 64'(frac) * 64'd675;
        secs = p >> SCALE_BITS;
        sub  = p & ((64'd1 << SCALE_BITS) - 1);
        r.second_fraction = (SCALE_BITS >= 32) ? 32'(sub >> (SCALE_BITS - 32))
                                               : 32'(sub << (32 - SCALE_BITS));
        r.hour   = 5'(secs / 3600);
        rem      = secs % 3600;
        r.minute = 6'(rem / 60);
        r.second = 6'(rem % 60);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_stamp seen, due;
        if (!i_rst_n) begin
            stamps_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = t_stamp'(i_m_tdata[$bits(t_stamp)-1:0]);
                if (stamps_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("unexpected result item %h", seen);
                end else begin
                    due = stamps_due.pop_front();
                    if (seen !== due) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display({"mismatch: expected %0d-%0d-%0d %0d:%0d:%0d frac %h, ",
                                      "got %0d-%0d-%0d %0d:%0d:%0d frac %h"},
                                     due.year, due.month, due.day_of_month, due.hour,
                                     due.minute, due.second, due.second_fraction,
                                     seen.year, seen.month, seen.day_of_month, seen.hour,
                                     seen.minute, seen.second, seen.second_fraction);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                stamps_due.push_back(civil_time_of(i_s_tdata[DAY_NUMBER_BITS-1:0],
                                         i_s_tdata[DAY_NUMBER_BITS +: FRACTION_BITS]));
        end
        o_pending_count = stamps_due.size();
    end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// tb_top: stimulus and verdict for the mjd to calendar time core
// depends on mjdc_pkg, mjd_to_calendar_time_core and mjdc_checker
`default_nettype none

module tb_top;
    import mjdc_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 1000;   // cycles with no item moving on either side

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // tdata: day_number, day_fraction, zero pad
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // tdata: year, month, day_of_month, hour, minute, second, second_fraction, zero pad
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    bit steady = 1'b0;                    // no gaps on either side while set

    always #5 i_clk = ~i_clk;

    mjd_to_calendar_time_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mjdc_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one item at the falling edge and hold it until the core takes it;
    // valid stays high between back-to-back items so it is never dropped and raised
    // in the same step
    task automatic send_stamp(input logic [DAY_NUMBER_BITS-1:0] mjd,
                              input logic [FRACTION_BITS-1:0]   frac,
                              input bit                         noisy_pad);
        logic [IN_DATA_BITS-1:0] word;
        int                      gap;
        gap  = gap_len();
        word = noisy_pad ? IN_DATA_BITS'({$urandom(), $urandom()}) : '0;
        word[DAY_NUMBER_BITS-1:0]              = mjd;
        word[DAY_NUMBER_BITS +: FRACTION_BITS] = frac;
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // receiver: ready in runs of random length, broken by stalls of random length
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = gap_len();
            if (stall > 0) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL mjd_to_calendar_time_core");
            $finish;
        end
    end

    initial begin
        logic [DAY_NUMBER_BITS-1:0] mjd;
        logic [FRACTION_BITS-1:0]   frac;
        int                         r;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, calendar edges and time of day edges
        send_stamp('0, '0, 1'b0);                        // epoch 1858-11-17 midnight
        send_stamp('1, '1, 1'b0);                        // last day number, end of day
        send_stamp(20'd0, 32'd1, 1'b0);                  // smallest nonzero fraction
        send_stamp(20'd51544, 32'h8000_0000, 1'b0);      // 2000-01-01 noon
        send_stamp(20'd51543, '1, 1'b0);                 // 1999-12-31 last tick
        send_stamp(20'd51603, 32'h4000_0000, 1'b0);      // 2000-02-29, leap century
        send_stamp(20'd51604, 32'h0, 1'b0);              // 2000-03-01
        send_stamp(20'd15078, 32'hC000_0000, 1'b0);      // 1900-02-28, no leap century
        send_stamp(20'd15079, 32'h0, 1'b0);              // 1900-03-01
        send_stamp(20'd58849, 32'h0000_C22F, 1'b0);      // 2020-01-01, first whole second
        send_stamp(20'd58850, 32'h0000_C22E, 1'b0);      // just under one second
        send_stamp(20'd40587, 32'h02D8_2D83, 1'b0);      // 1970-01-01 near sixteen minutes
        send_stamp(20'd59215, 32'hAAAA_AAAA, 1'b0);      // alternating fraction bits
        send_stamp(20'hAAAAA, 32'h5555_5555, 1'b0);      // alternating day number bits
        send_stamp(20'h55555, 32'hFFFF_0000, 1'b0);
        send_stamp(20'd1048574, 32'h7FFF_FFFF, 1'b0);
        send_stamp(20'd44, 32'hFFFF_FFFE, 1'b0);         // 1858-12-31, year change
        send_stamp(20'd45, 32'h0, 1'b1);                 // noise in the pad bits
        send_stamp(20'd1000000, 32'h0123_4567, 1'b1);

        // random: mostly the whole day number range, plus present era and the top end;
        // one stretch in the middle runs with no gaps on either side
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 600 && n < 900);
            r = $urandom_range(0, 99);
            if (r < 65)
                mjd = DAY_NUMBER_BITS'($urandom());
            else if (r < 85)
                mjd = DAY_NUMBER_BITS'($urandom_range(40000, 80000));
            else
                mjd = DAY_NUMBER_BITS'((1 << DAY_NUMBER_BITS) - 1 - $urandom_range(0, 600));
            r = $urandom_range(0, 99);
            if (r < 80)
                frac = FRACTION_BITS'($urandom());
            else if (r < 90)
                frac = FRACTION_BITS'($urandom_range(0, 100000));
            else
                frac = '1 - FRACTION_BITS'($urandom_range(0, 100000));
            send_stamp(mjd, frac, ($urandom_range(0, 3) == 0));
        end
        steady = 1'b0;

        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (STAGES + 5) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS mjd_to_calendar_time_core");
        else
            $display("FAIL mjd_to_calendar_time_core");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/mjdc_pkg.sv
hdl/mjd_to_calendar_time_core.sv
bench/mjdc_checker.sv
bench/tb_top.sv
